/* rtl/sc1kd_pkg.sv */
// Shared types, scan code constants and lookup tables for the set 1 key decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sc1kd_pkg;

  localparam int unsigned SKIP_W           = 3;
  localparam int unsigned PAUSE_SKIP_DEF   = 5;
  localparam int unsigned USAGE_W          = 8;
  localparam int unsigned MOD_W            = 7;
  localparam int unsigned CODE_W           = 7;

  localparam logic [7:0] SC_PAUSE_PREFIX = 8'hE1;
  localparam logic [7:0] SC_EXT_PREFIX   = 8'hE0;

  localparam logic [CODE_W-1:0] CODE_CTRL   = 7'h1D;
  localparam logic [CODE_W-1:0] CODE_LSHIFT = 7'h2A;
  localparam logic [CODE_W-1:0] CODE_RSHIFT = 7'h36;
  localparam logic [CODE_W-1:0] CODE_ALT    = 7'h38;

  localparam logic [MOD_W-1:0] MOD_LCTRL  = 7'h01;
  localparam logic [MOD_W-1:0] MOD_LSHIFT = 7'h02;
  localparam logic [MOD_W-1:0] MOD_LALT   = 7'h04;
  localparam logic [MOD_W-1:0] MOD_RCTRL  = 7'h10;
  localparam logic [MOD_W-1:0] MOD_RSHIFT = 7'h20;
  localparam logic [MOD_W-1:0] MOD_RALT   = 7'h40;

  typedef struct packed {
    logic               vld;
    logic [USAGE_W-1:0] usage;
    logic [MOD_W-1:0]   mods;
  } dec_result_t;

  localparam logic [USAGE_W-1:0] PLAIN_USAGE [128] = '{
    8'd0,  8'd41, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35,
    8'd36, 8'd37, 8'd38, 8'd39, 8'd45, 8'd46, 8'd42, 8'd43,
    8'd20, 8'd26, 8'd8,  8'd21, 8'd23, 8'd28, 8'd24, 8'd12,
    8'd18, 8'd19, 8'd47, 8'd48, 8'd40, 8'd0,  8'd4,  8'd22,
    8'd7,  8'd9,  8'd10, 8'd11, 8'd13, 8'd14, 8'd15, 8'd51,
    8'd52, 8'd53, 8'd0,  8'd49, 8'd29, 8'd27, 8'd6,  8'd25,
    8'd5,  8'd17, 8'd16, 8'd54, 8'd55, 8'd56, 8'd0,  8'd0,
    8'd0,  8'd44, 8'd57, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0
  };

  function automatic logic [USAGE_W-1:0] ext_usage(input logic [CODE_W-1:0] code);
    logic [USAGE_W-1:0] u;
    unique case (code)
      7'h1C:   u = 8'd88;
      7'h47:   u = 8'd74;
      7'h49:   u = 8'd75;
      7'h53:   u = 8'd76;
      7'h4F:   u = 8'd77;
      7'h51:   u = 8'd78;
      7'h4D:   u = 8'd79;
      7'h4B:   u = 8'd80;
      7'h50:   u = 8'd81;
      7'h48:   u = 8'd82;
      default: u = '0;
    endcase
    return u;
  endfunction

  function automatic logic [MOD_W-1:0] modifier_bit(input logic [CODE_W-1:0] code,
                                                    input logic ext);
    logic [MOD_W-1:0] m;
    m = '0;
    if (code == CODE_CTRL) begin
      m = ext ? MOD_RCTRL : MOD_LCTRL;
    end else if (code == CODE_LSHIFT && !ext) begin
      m = MOD_LSHIFT;
    end else if (code == CODE_RSHIFT && !ext) begin
      m = MOD_RSHIFT;
    end else if (code == CODE_ALT) begin
      m = ext ? MOD_RALT : MOD_LALT;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/scancode_set1_key_decoder.sv */
// Top level of the scan code set 1 to HID usage key decoder.
// Depends on sc1kd_pkg, sc1kd_decode and sc1kd_out_reg.
`default_nettype none

// Takes one scan code byte per cycle and delivers each key press request from a
// result register in the cycle after its byte; a new byte is accepted in the same
// cycle the held result is taken, so throughput is one byte per clock unless the consumer stalls.
// Prefix bytes, modifier changes, releases and unmapped keys produce no request.

module scancode_set1_key_decoder
  import sc1kd_pkg::*;
#(
  parameter int unsigned PAUSE_SKIP_BYTES = PAUSE_SKIP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_scan_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [USAGE_W-1:0] out_key_usage,
  output logic [MOD_W-1:0]   out_modifier_mask
);

  logic        in_accept;
  dec_result_t res;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  sc1kd_decode #(
    .PAUSE_SKIP_BYTES(PAUSE_SKIP_BYTES)
  ) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .scan_byte(in_scan_byte),
    .res      (res)
  );

  sc1kd_out_reg u_out_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (in_accept),
    .res              (res),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_key_usage    (out_key_usage),
    .out_modifier_mask(out_modifier_mask)
  );

endmodule

`default_nettype wire

/* rtl/sc1kd_decode.sv */
// Decoder state (modifier mask, extended flag, pause skip count) and byte decode.
// Depends on sc1kd_pkg for the tables, constants and result type.
`default_nettype none

module sc1kd_decode
  import sc1kd_pkg::*;
#(
  parameter int unsigned PAUSE_SKIP_BYTES = PAUSE_SKIP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  scan_byte,
  output dec_result_t res
);

  logic [MOD_W-1:0]  held_r, held_nxt;
  logic              ext_r, ext_nxt;
  logic [SKIP_W-1:0] skip_r, skip_nxt;

  logic              released;
  logic [CODE_W-1:0] code;
  logic [MOD_W-1:0]  mod;
  logic [USAGE_W-1:0] usage;

  assign released = scan_byte[7];
  assign code     = scan_byte[CODE_W-1:0];
  assign mod      = modifier_bit(code, ext_r);
  assign usage    = ext_r ? ext_usage(code) : PLAIN_USAGE[code];

  always_comb begin
    held_nxt  = held_r;
    ext_nxt   = ext_r;
    skip_nxt  = skip_r;
    res.vld   = 1'b0;
    res.usage = usage;
    res.mods  = held_r;
    if (accept) begin
      priority if (skip_r != '0) begin
        skip_nxt = skip_r - 1'b1;
      end else if (scan_byte == SC_PAUSE_PREFIX) begin
        ext_nxt  = 1'b0;
        skip_nxt = SKIP_W'(PAUSE_SKIP_BYTES);
      end else if (scan_byte == SC_EXT_PREFIX) begin
        ext_nxt = 1'b1;
      end else begin
        ext_nxt = 1'b0;
        if (mod != '0) begin
          held_nxt = released ? (held_r & ~mod) : (held_r | mod);
        end else if (!released && usage != '0) begin
          res.vld = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      ext_r  <= 1'b0;
      skip_r <= '0;
    end else begin
      held_r <= held_nxt;
      ext_r  <= ext_nxt;
      skip_r <= skip_nxt;
    end
  end

  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && skip_r != '0 |-> !res.vld && held_nxt == held_r)
    else $error("byte inside a pause sequence produced a result or changed modifiers");

  a_skip_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && skip_r != '0 |=> skip_r == $past(skip_r) - 1'b1)
    else $error("pause skip count did not step down");

  a_pause_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept && skip_r == '0 && scan_byte == SC_PAUSE_PREFIX
    |=> skip_r == SKIP_W'(PAUSE_SKIP_BYTES) && !ext_r)
    else $error("pause prefix did not load the skip count");

  a_ext_set: assert property (@(posedge clk) disable iff (!rst_n)
    accept && skip_r == '0 && scan_byte == SC_EXT_PREFIX |=> ext_r)
    else $error("extended prefix did not set the extended flag");

  a_bit3_clear: assert property (@(posedge clk) disable iff (!rst_n)
    held_r[3] == 1'b0)
    else $error("unused modifier bit became set");

endmodule

`default_nettype wire

/* rtl/sc1kd_out_reg.sv */
// Result register with valid/stall handshake toward the consumer.
// Depends on sc1kd_pkg for the result type.
`default_nettype none

module sc1kd_out_reg
  import sc1kd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  dec_result_t        res,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [USAGE_W-1:0] out_key_usage,
  output logic [MOD_W-1:0]   out_modifier_mask
);

  logic               valid_r, valid_nxt;
  logic [USAGE_W-1:0] usage_r;
  logic [MOD_W-1:0]   mods_r;

  always_comb begin
    priority if (load) begin
      valid_nxt = res.vld;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.vld) begin
      usage_r <= res.usage;
      mods_r  <= res.mods;
    end
  end

  assign out_valid         = valid_r;
  assign out_key_usage     = usage_r;
  assign out_modifier_mask = mods_r;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for scancode_set1_key_decoder: a directed table, then random
// scan code sequences, predicted in the bench and compared request by request.
// Depends on sc1kd_pkg for the port widths.
`timescale 1ns / 100ps

module tb_top;
  import sc1kd_pkg::*;

  localparam int IDLE_LIMIT   = 400;
  localparam int RANDOM_BYTES = 1300;
  localparam int DRAIN_CYCLES = 10;
  localparam int PAUSE_TAIL   = 5;

  localparam logic [7:0] SCAN_PAUSE  = 8'hE1;
  localparam logic [7:0] SCAN_EXT    = 8'hE0;
  localparam logic [7:0] REL_BIT     = 8'h80;
  localparam logic [7:0] SCAN_CTRL   = 8'h1D;
  localparam logic [7:0] SCAN_LSHIFT = 8'h2A;
  localparam logic [7:0] SCAN_RSHIFT = 8'h36;
  localparam logic [7:0] SCAN_ALT    = 8'h38;

  localparam logic [6:0] MASK_LCTRL  = 7'h01;
  localparam logic [6:0] MASK_LSHIFT = 7'h02;
  localparam logic [6:0] MASK_LALT   = 7'h04;
  localparam logic [6:0] MASK_RCTRL  = 7'h10;
  localparam logic [6:0] MASK_RSHIFT = 7'h20;
  localparam logic [6:0] MASK_RALT   = 7'h40;

  localparam logic [7:0] KEY_USAGE_PLAIN [128] = '{
    8'd0,  8'd41, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35,
    8'd36, 8'd37, 8'd38, 8'd39, 8'd45, 8'd46, 8'd42, 8'd43,
    8'd20, 8'd26, 8'd8,  8'd21, 8'd23, 8'd28, 8'd24, 8'd12,
    8'd18, 8'd19, 8'd47, 8'd48, 8'd40, 8'd0,  8'd4,  8'd22,
    8'd7,  8'd9,  8'd10, 8'd11, 8'd13, 8'd14, 8'd15, 8'd51,
    8'd52, 8'd53, 8'd0,  8'd49, 8'd29, 8'd27, 8'd6,  8'd25,
    8'd5,  8'd17, 8'd16, 8'd54, 8'd55, 8'd56, 8'd0,  8'd0,
    8'd0,  8'd44, 8'd57, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0
  };

  localparam logic [7:0] NAV_SCAN [10] = '{
    8'h1C, 8'h47, 8'h49, 8'h53, 8'h4F, 8'h51, 8'h4D, 8'h4B, 8'h50, 8'h48
  };

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NONE,
    ROW_RESULT
  } row_kind_t;

  typedef struct packed {
    logic [7:0] scan;
    row_kind_t  kind;
    logic [7:0] usage;
    logic [6:0] mask;
    logic       drain_first;
  } plan_row_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] usage;
    logic [6:0] mask;
  } key_report_t;

  localparam int DIRECTED_ROWS = 28;
  localparam plan_row_t DIRECTED_PLAN [DIRECTED_ROWS] = '{
    '{8'h01,                 ROW_RESULT, 8'd41, 7'h00, 1'b0},
    '{SCAN_CTRL,             ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{SCAN_LSHIFT,           ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{SCAN_ALT,              ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{SCAN_EXT,              ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{SCAN_CTRL,             ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{SCAN_EXT,              ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{SCAN_ALT,              ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{8'h1E,                 ROW_RESULT, 8'd4,  7'h57, 1'b0},
    '{SCAN_EXT,              ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{SCAN_RSHIFT,           ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{SCAN_EXT,              ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{SCAN_EXT,              ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{8'h48,                 ROW_RESULT, 8'd82, 7'h57, 1'b0},
    '{SCAN_EXT,              ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{REL_BIT | SCAN_CTRL,   ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{REL_BIT | SCAN_LSHIFT, ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{8'h7F,                 ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{8'hFF,                 ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{8'h00,                 ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{SCAN_EXT,              ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{SCAN_PAUSE,            ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{8'h1C,                 ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{SCAN_EXT,              ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{REL_BIT | SCAN_CTRL,   ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{REL_BIT | SCAN_ALT,    ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{SCAN_CTRL,             ROW_NONE,   8'd0,  7'h00, 1'b0},
    '{8'h1C,                 ROW_RESULT, 8'd40, 7'h45, 1'b0}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_scan_byte;
  logic               out_valid;
  logic               out_stall;
  logic [USAGE_W-1:0] out_key_usage;
  logic [MOD_W-1:0]   out_modifier_mask;

  plan_row_t   scan_plan [$];
  key_report_t pending_keys [$];
  logic [6:0]  held_mask;
  logic        ext_armed;
  logic [2:0]  skip_left;
  int          accepted_bytes;
  int          mismatches;
  int          idle_cycles;
  bit          tx_calm;
  bit          rx_calm;

  scancode_set1_key_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_scan_byte      (in_scan_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_key_usage     (out_key_usage),
    .out_modifier_mask (out_modifier_mask)
  );

  function automatic key_report_t decode_scan(input logic [7:0] scan);
    key_report_t rep;
    logic [7:0]  code;
    logic [6:0]  mod_sel;
    logic [7:0]  usage;
    logic        ext;
    rep = '0;
    if (skip_left != 0) begin
      skip_left = skip_left - 3'd1;
      return rep;
    end
    if (scan == SCAN_PAUSE) begin
      ext_armed = 1'b0;
      skip_left = 3'(PAUSE_TAIL);
      return rep;
    end
    if (scan == SCAN_EXT) begin
      ext_armed = 1'b1;
      return rep;
    end
    code = {1'b0, scan[6:0]};
    ext = ext_armed;
    ext_armed = 1'b0;
    mod_sel = '0;
    if (code == SCAN_CTRL) begin
      mod_sel = ext ? MASK_RCTRL : MASK_LCTRL;
    end else if (code == SCAN_ALT) begin
      mod_sel = ext ? MASK_RALT : MASK_LALT;
    end else if (code == SCAN_LSHIFT && !ext) begin
      mod_sel = MASK_LSHIFT;
    end else if (code == SCAN_RSHIFT && !ext) begin
      mod_sel = MASK_RSHIFT;
    end
    if (mod_sel != 0) begin
      held_mask = scan[7] ? (held_mask & ~mod_sel) : (held_mask | mod_sel);
    end else if (!scan[7]) begin
      usage = 8'd0;
      if (!ext) begin
        usage = KEY_USAGE_PLAIN[code[6:0]];
      end else begin
        case (code)
          8'h1C:   usage = 8'd88;
          8'h47:   usage = 8'd74;
          8'h49:   usage = 8'd75;
          8'h53:   usage = 8'd76;
          8'h4F:   usage = 8'd77;
          8'h51:   usage = 8'd78;
          8'h4D:   usage = 8'd79;
          8'h4B:   usage = 8'd80;
          8'h50:   usage = 8'd81;
          8'h48:   usage = 8'd82;
          default: usage = 8'd0;
        endcase
      end
      if (usage != 0) begin
        rep.hit = 1'b1;
        rep.usage = usage;
        rep.mask = held_mask;
      end
    end
    return rep;
  endfunction

  function automatic void add_scan(input logic [7:0] scan);
    scan_plan.push_back('{scan, ROW_PREDICT, 8'd0, 7'd0, $urandom_range(0, 149) == 0});
  endfunction

  function automatic int idle_draw(inout bit calm);
    if ($urandom_range(0, 29) == 0) begin
      calm = !calm;
    end
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int         gap;
    int         pick;
    logic [7:0] b;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_scan_byte = 8'h00;
    out_stall = 1'b0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    foreach (DIRECTED_PLAN[i]) begin
      scan_plan.push_back(DIRECTED_PLAN[i]);
    end
    while (scan_plan.size() < DIRECTED_ROWS + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        b = 8'($urandom_range(0, 8'h3A));
        add_scan(b);
        if ($urandom_range(0, 1) != 0) begin
          add_scan(b | REL_BIT);
        end
      end else if (pick < 55) begin
        case ($urandom_range(0, 3))
          0:       b = SCAN_CTRL;
          1:       b = SCAN_LSHIFT;
          2:       b = SCAN_RSHIFT;
          default: b = SCAN_ALT;
        endcase
        if ($urandom_range(0, 4) < 2) begin
          add_scan(SCAN_EXT);
        end
        add_scan(($urandom_range(0, 1) != 0) ? (b | REL_BIT) : b);
      end else if (pick < 75) begin
        add_scan(SCAN_EXT);
        b = NAV_SCAN[$urandom_range(0, 9)];
        if ($urandom_range(0, 3) == 0) begin
          b = 8'($urandom_range(0, 127));
        end
        if ($urandom_range(0, 3) == 0) begin
          b = b | REL_BIT;
        end
        add_scan(b);
      end else if (pick < 80) begin
        if ($urandom_range(0, 2) == 0) begin
          add_scan(SCAN_EXT);
        end
        add_scan(SCAN_PAUSE);
        repeat (PAUSE_TAIL) add_scan(8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        add_scan(8'($urandom_range(0, 255)));
      end else begin
        add_scan(8'($urandom_range(8'h40, 8'hFF)));
      end
    end
    scan_plan[DIRECTED_ROWS].drain_first = 1'b1;

    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    foreach (scan_plan[i]) begin
      if (scan_plan[i].drain_first) begin
        in_valid = 1'b0;
        while (pending_keys.size() != 0) @(negedge clk);
      end
      gap = idle_draw(tx_calm);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid = 1'b1;
      in_scan_byte = scan_plan[i].scan;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
    end
    in_valid = 1'b0;
    while (pending_keys.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_keys.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    int gap;
    while (!rst_n) @(negedge clk);
    forever begin
      gap = idle_draw(rx_calm);
      out_stall = (gap != 0);
      repeat (gap) @(negedge clk);
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    key_report_t pred;
    key_report_t exp_key;
    plan_row_t   row;
    if (!rst_n) begin
      held_mask = '0;
      ext_armed = 1'b0;
      skip_left = '0;
      accepted_bytes = 0;
      mismatches = 0;
      pending_keys.delete();
    end else begin
      if (in_valid && !in_stall) begin
        row = scan_plan[accepted_bytes];
        accepted_bytes++;
        pred = decode_scan(in_scan_byte);
        if (row.kind == ROW_RESULT) begin
          pending_keys.push_back('{1'b1, row.usage, row.mask});
        end else if (row.kind == ROW_PREDICT && pred.hit) begin
          pending_keys.push_back(pred);
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_keys.size() == 0) begin
          $display("%0t: request expected none actual usage=%0d mask=%02h", $time,
                   out_key_usage, out_modifier_mask);
          mismatches++;
        end else begin
          exp_key = pending_keys.pop_front();
          if (out_key_usage !== exp_key.usage) begin
            $display("%0t: key_usage expected %0d actual %0d", $time,
                     exp_key.usage, out_key_usage);
            mismatches++;
          end
          if (out_modifier_mask !== exp_key.mask) begin
            $display("%0t: modifier_mask expected %02h actual %02h", $time,
                     exp_key.mask, out_modifier_mask);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
